@@ sv/b64_pkg.sv @@
// ----------------------------------------------------------------------------
// b64_pkg
// shared types and constants of the binary64 add/sub/mul/div pipeline
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam int EXP_W    = 11;
  localparam int FRAC_W   = 52;
  localparam int SIG_W    = FRAC_W + 1;
  // working exponent, signed, wide enough for product and quotient ranges
  localparam int EW       = 14;
  localparam int DIV_STEPS = 63;
  localparam int NORM_STEPS = 6;
  // low half of a significand for the partial products, high half is 27 bits
  localparam int LO_W     = 26;
  localparam int HI_W     = SIG_W - LO_W;
  localparam int GRD_W    = 10;

  localparam logic [EXP_W-1:0]     EXP_MAX  = 11'h7ff;
  localparam logic [63:0]          QNAN     = 64'h7FF8000000000000;
  localparam logic signed [EW-1:0] BIAS     = 14'sd1023;
  localparam logic signed [EW-1:0] EXP_OVF  = 14'sd2047;
  localparam logic [GRD_W-1:0]     HALF     = 10'h200;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic                 special;
    logic [63:0]          spec_val;
    op_t                  op;
    logic                 sign;
    logic signed [EW-1:0] exp;
    logic [63:0]          acc;
    logic [63:0]          aux;
    logic [SIG_W:0]       rem;
    logic [SIG_W-1:0]     dvsr;
    logic [EXP_W-1:0]     shamt;
    logic                 eff_sub;
    logic [2*HI_W-1:0]    pp_hh;
    logic [2*HI_W-1:0]    pp_hl;
    logic [2*HI_W-1:0]    pp_lh;
    logic [2*HI_W-1:0]    pp_ll;
  } item_t;

endpackage

@@ sv/b64_req_if.sv @@
// ----------------------------------------------------------------------------
// b64_req_if
// request channel: opcode and two binary64 operands
// ----------------------------------------------------------------------------
interface b64_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] operand_a;
  logic [63:0] operand_b;

  modport source (output valid, output opcode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input opcode, input operand_a, input operand_b,
                  output ready);
endinterface

@@ sv/b64_rsp_if.sv @@
// ----------------------------------------------------------------------------
// b64_rsp_if
// result channel: binary64 result and exception flags
// ----------------------------------------------------------------------------
interface b64_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;
  logic        overflow_flag;
  logic        underflow_flag;

  modport source (output valid, output result_value, output overflow_flag,
                  output underflow_flag, input ready);
  modport sink   (input valid, input result_value, input overflow_flag,
                  input underflow_flag, output ready);
endinterface

@@ sv/b64_front.sv @@
// ----------------------------------------------------------------------------
// b64_front
// decode, special cases, alignment / partial products, add and product sum
// ----------------------------------------------------------------------------
module b64_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  b64_pkg::op_t      op,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output logic              out_valid,
  output b64_pkg::item_t    out_item
);

  b64_pkg::item_t it0, it0_next, it1, it1_next, it2_next;
  logic v0, v1;

  logic                          sa, sbx, swap;
  logic [b64_pkg::EXP_W-1:0]     ea, eb, big_e, small_e;
  logic [b64_pkg::FRAC_W-1:0]    fa, fb;
  logic [b64_pkg::SIG_W-1:0]     ma, mb, big_m, small_m;
  logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [63:0] bv;

  // stage 0: decode
  always_comb begin
    sa     = a[63];
    sbx    = b[63] ^ (op == b64_pkg::OP_SUB);
    ea     = a[62:52];
    eb     = b[62:52];
    fa     = a[51:0];
    fb     = b[51:0];
    ma     = {1'b1, fa};
    mb     = {1'b1, fb};
    nan_a  = (ea == b64_pkg::EXP_MAX) && (fa != '0);
    nan_b  = (eb == b64_pkg::EXP_MAX) && (fb != '0);
    inf_a  = (ea == b64_pkg::EXP_MAX) && (fa == '0);
    inf_b  = (eb == b64_pkg::EXP_MAX) && (fb == '0);
    zero_a = (ea == '0);
    zero_b = (eb == '0);
    bv     = {sbx, b[62:0]};
    swap   = b[62:0] > a[62:0];
    big_e   = swap ? eb : ea;
    small_e = swap ? ea : eb;
    big_m   = swap ? mb : ma;
    small_m = swap ? ma : mb;
    it0_next    = '0;
    it0_next.op = op;
    case (op)
      b64_pkg::OP_ADD, b64_pkg::OP_SUB: begin
        it0_next.sign    = swap ? sbx : sa;
        it0_next.exp     = $signed({3'b000, big_e}) + 14'sd1;
        it0_next.acc     = {2'b00, big_m, 9'b0};
        it0_next.aux     = {2'b00, small_m, 9'b0};
        it0_next.shamt   = big_e - small_e;
        it0_next.eff_sub = sa ^ sbx;
        it0_next.special = 1'b1;
        if (nan_a || nan_b) begin
          it0_next.spec_val = b64_pkg::QNAN;
        end else if (inf_a && inf_b) begin
          it0_next.spec_val = (sa == sbx) ? {sa, b64_pkg::EXP_MAX, 52'b0} : b64_pkg::QNAN;
        end else if (inf_a) begin
          it0_next.spec_val = {sa, b64_pkg::EXP_MAX, 52'b0};
        end else if (inf_b) begin
          it0_next.spec_val = {sbx, b64_pkg::EXP_MAX, 52'b0};
        end else if (zero_a && zero_b) begin
          it0_next.spec_val = {sa & sbx, 63'b0};
        end else if (zero_a) begin
          it0_next.spec_val = bv;
        end else if (zero_b) begin
          it0_next.spec_val = a;
        end else begin
          it0_next.special = 1'b0;
        end
      end
      b64_pkg::OP_MUL: begin
        it0_next.sign    = sa ^ b[63];
        it0_next.exp     = $signed({3'b000, ea}) + $signed({3'b000, eb}) - b64_pkg::BIAS;
        it0_next.acc     = {11'b0, ma};
        it0_next.aux     = {11'b0, mb};
        it0_next.special = 1'b1;
        if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
          it0_next.spec_val = b64_pkg::QNAN;
        end else if (inf_a || inf_b) begin
          it0_next.spec_val = {sa ^ b[63], b64_pkg::EXP_MAX, 52'b0};
        end else if (zero_a || zero_b) begin
          it0_next.spec_val = {sa ^ b[63], 63'b0};
        end else begin
          it0_next.special = 1'b0;
        end
      end
      b64_pkg::OP_DIV: begin
        it0_next.sign    = sa ^ b[63];
        it0_next.dvsr    = mb;
        // pre-scale so the first quotient bit is one
        if (ma < mb) begin
          it0_next.rem = {ma, 1'b0};
          it0_next.exp = $signed({3'b000, ea}) - $signed({3'b000, eb})
                         + b64_pkg::BIAS - 14'sd1;
        end else begin
          it0_next.rem = {1'b0, ma};
          it0_next.exp = $signed({3'b000, ea}) - $signed({3'b000, eb}) + b64_pkg::BIAS;
        end
        it0_next.special = 1'b1;
        if (nan_a || nan_b || (inf_a && inf_b) || (zero_a && zero_b)) begin
          it0_next.spec_val = b64_pkg::QNAN;
        end else if (inf_a || zero_b) begin
          it0_next.spec_val = {sa ^ b[63], b64_pkg::EXP_MAX, 52'b0};
        end else if (inf_b || zero_a) begin
          it0_next.spec_val = {sa ^ b[63], 63'b0};
        end else begin
          it0_next.special = 1'b0;
        end
      end
      default: it0_next.special = 1'b1;
    endcase
  end

  logic [b64_pkg::HI_W-1:0] ah, bh;
  logic [b64_pkg::LO_W-1:0] al, bl;
  logic [63:0] shifted;
  logic        lost;

  // stage 1: partial products or operand alignment
  always_comb begin
    ah = it0.acc[b64_pkg::SIG_W-1:b64_pkg::LO_W];
    al = it0.acc[b64_pkg::LO_W-1:0];
    bh = it0.aux[b64_pkg::SIG_W-1:b64_pkg::LO_W];
    bl = it0.aux[b64_pkg::LO_W-1:0];
    shifted = it0.aux >> it0.shamt;
    lost    = |(it0.aux & ~({64{1'b1}} << it0.shamt));
    it1_next = it0;
    if (it0.op == b64_pkg::OP_MUL) begin
      it1_next.pp_hh = ah * bh;
      it1_next.pp_hl = ah * bl;
      it1_next.pp_lh = al * bh;
      it1_next.pp_ll = al * bl;
    end else if (it0.op == b64_pkg::OP_ADD || it0.op == b64_pkg::OP_SUB) begin
      if (it0.shamt >= 11'd63) begin
        it1_next.aux = 64'd1;
      end else begin
        it1_next.aux = shifted | {63'b0, lost};
      end
    end
  end

  logic [105:0] prod;
  logic [63:0]  sum;

  // stage 2: sum of partial products or significand add
  always_comb begin
    prod = (106'(it1.pp_hh) << 52) + (106'(it1.pp_hl) << b64_pkg::LO_W)
         + (106'(it1.pp_lh) << b64_pkg::LO_W) + 106'(it1.pp_ll);
    sum  = it1.eff_sub ? (it1.acc - it1.aux) : (it1.acc + it1.aux);
    it2_next = it1;
    if (it1.op == b64_pkg::OP_MUL) begin
      if (prod[105]) begin
        it2_next.acc = {1'b0, prod[105:43]} | {63'b0, |prod[42:0]};
        it2_next.exp = it1.exp + 14'sd1;
      end else begin
        it2_next.acc = {1'b0, prod[104:42]} | {63'b0, |prod[41:0]};
      end
    end else if (it1.op == b64_pkg::OP_ADD || it1.op == b64_pkg::OP_SUB) begin
      it2_next.acc = sum;
      if (!it1.special && sum == '0) begin
        it2_next.special  = 1'b1;
        it2_next.spec_val = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= in_valid;
      v1        <= v0;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0      <= it0_next;
      it1      <= it1_next;
      out_item <= it2_next;
    end
  end

endmodule

@@ sv/b64_cell.sv @@
// ----------------------------------------------------------------------------
// b64_cell
// one restoring division step; other requests pass through unchanged
// ----------------------------------------------------------------------------
module b64_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  b64_pkg::item_t in_item,
  output logic           out_valid,
  output b64_pkg::item_t out_item
);

  b64_pkg::item_t item_next;
  logic                     ge;
  logic [b64_pkg::SIG_W:0]  diff;

  always_comb begin
    ge   = in_item.rem >= {1'b0, in_item.dvsr};
    diff = ge ? (in_item.rem - {1'b0, in_item.dvsr}) : in_item.rem;
    item_next = in_item;
    if (!in_item.special && in_item.op == b64_pkg::OP_DIV) begin
      // partial remainder stays below the divisor after the subtract
      item_next.rem = {diff[b64_pkg::SIG_W-1:0], 1'b0};
      item_next.acc = {in_item.acc[62:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

@@ sv/b64_norm.sv @@
// ----------------------------------------------------------------------------
// b64_norm
// leading-one normalization in six registered shift steps (32 down to 1)
// ----------------------------------------------------------------------------
module b64_norm (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  b64_pkg::item_t in_item,
  output logic           out_valid,
  output b64_pkg::item_t out_item
);

  b64_pkg::item_t items [b64_pkg::NORM_STEPS+1];
  logic           vld   [b64_pkg::NORM_STEPS+1];

  assign items[0] = in_item;
  assign vld[0]   = in_valid;

  for (genvar k = 0; k < b64_pkg::NORM_STEPS; k++) begin : g_step
    localparam int AMT = 32 >> k;
    b64_pkg::item_t step_next;

    always_comb begin
      step_next = items[k];
      if (!items[k].special && items[k].acc[62 -: AMT] == '0) begin
        step_next.acc = items[k].acc << AMT;
        step_next.exp = items[k].exp - 14'(AMT);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        items[k+1] <= step_next;
      end
    end
  end

  assign out_valid = vld[b64_pkg::NORM_STEPS];
  assign out_item  = items[b64_pkg::NORM_STEPS];

endmodule

@@ sv/b64_round.sv @@
// ----------------------------------------------------------------------------
// b64_round
// round to nearest even, range check and packing into the result register
// ----------------------------------------------------------------------------
module b64_round (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  b64_pkg::item_t in_item,
  output logic           out_valid,
  output logic [63:0]    value,
  output logic           ovf,
  output logic           unf
);

  logic [63:0]                 m;
  logic [53:0]                 keep, rounded;
  logic [b64_pkg::GRD_W-1:0]   grd;
  logic                        inc;
  logic [b64_pkg::FRAC_W-1:0]  frac;
  logic signed [b64_pkg::EW-1:0] e;
  logic [63:0] value_next;
  logic        ovf_next, unf_next;

  always_comb begin
    // remainder of the division acts as sticky bit
    m = in_item.acc | {63'b0, (in_item.op == b64_pkg::OP_DIV) && (in_item.rem != '0)};
    keep = m[63:b64_pkg::GRD_W];
    grd  = m[b64_pkg::GRD_W-1:0];
    inc  = (grd > b64_pkg::HALF) || ((grd == b64_pkg::HALF) && keep[0]);
    rounded = keep + 54'(inc);
    if (rounded[53]) begin
      frac = rounded[52:1];
      e    = in_item.exp + 14'sd1;
    end else begin
      frac = rounded[51:0];
      e    = in_item.exp;
    end
    ovf_next   = 1'b0;
    unf_next   = 1'b0;
    if (in_item.special) begin
      value_next = in_item.spec_val;
    end else if (e >= b64_pkg::EXP_OVF) begin
      value_next = {in_item.sign, b64_pkg::EXP_MAX, 52'b0};
      ovf_next   = 1'b1;
    end else if (e <= 14'sd0) begin
      value_next = {in_item.sign, 63'b0};
      unf_next   = 1'b1;
    end else begin
      value_next = {in_item.sign, e[b64_pkg::EXP_W-1:0], frac};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= value_next;
      ovf   <= ovf_next;
      unf   <= unf_next;
    end
  end

endmodule

@@ sv/binary64_add_sub_mul_div.sv @@
// ----------------------------------------------------------------------------
// binary64_add_sub_mul_div
// pipelined binary64 add / subtract / multiply / divide, round to nearest even
// ----------------------------------------------------------------------------
// usage
// - req carries opcode (add, sub, mul, div) and two binary64 operands;
//   a request is taken when req.valid and req.ready are both high
// - rsp returns the result and the overflow / underflow flags in request order
// - a request passes 3 front stages (decode, alignment or partial products, add
//   or product sum), 63 division cells, 6 normalization steps and the rounding
//   stage that drives rsp
// - throughput is one request per cycle for every opcode mix while rsp does not
//   stall; the row of 63 division cells, one quotient bit each, sets the depth
// - subnormals are flushed to zero, NaN and invalid cases give the quiet NaN
// - rst (synchronous) empties the pipeline; no result is shown after it
// - when rsp stalls with a result waiting, the whole pipeline holds and
//   req.ready drops; req.ready is high whenever rsp is empty or taken
// ----------------------------------------------------------------------------
module binary64_add_sub_mul_div (
  input logic       clk,
  input logic       rst,
  b64_req_if.sink   req,
  b64_rsp_if.source rsp
);

  // pipeline advances unless a finished result waits
  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  b64_pkg::item_t items [b64_pkg::DIV_STEPS+1];
  logic           vld   [b64_pkg::DIV_STEPS+1];
  b64_pkg::item_t norm_item;
  logic           norm_valid;

  b64_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req.valid),
    .op        (b64_pkg::op_t'(req.opcode)),
    .a         (req.operand_a),
    .b         (req.operand_b),
    .out_valid (vld[0]),
    .out_item  (items[0])
  );

  // row of division cells, one quotient bit per cell
  for (genvar i = 0; i < b64_pkg::DIV_STEPS; i++) begin : g_cell
    b64_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vld[i]),
      .in_item   (items[i]),
      .out_valid (vld[i+1]),
      .out_item  (items[i+1])
    );
  end

  b64_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld[b64_pkg::DIV_STEPS]),
    .in_item   (items[b64_pkg::DIV_STEPS]),
    .out_valid (norm_valid),
    .out_item  (norm_item)
  );

  b64_round u_round (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (norm_valid),
    .in_item   (norm_item),
    .out_valid (rsp.valid),
    .value     (rsp.result_value),
    .ovf       (rsp.overflow_flag),
    .unf       (rsp.underflow_flag)
  );

`ifndef SYNTH
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.overflow_flag && rsp.underflow_flag))
    else $error("both flags raised");

  a_ovf_inf: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.overflow_flag) |-> (rsp.result_value[62:0] == 63'h7FF0000000000000))
    else $error("overflow without infinity");

  a_unf_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.underflow_flag) |-> (rsp.result_value[62:0] == 63'h0))
    else $error("underflow without zero");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !req.ready)
    else $error("request taken while result stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp.valid)
    else $error("result after reset");
`endif

endmodule

@@ tb/tb_binary64_add_sub_mul_div.sv @@
// ----------------------------------------------------------------------------
// tb_binary64_add_sub_mul_div
// self-checking bench for the binary64 add / subtract / multiply / divide pipe
// ----------------------------------------------------------------------------
// a directed table (extremes, every opcode, NaN, infinities, zeros, subnormals,
// overflow, underflow, cancellation) is followed by random requests biased
// toward nearby exponents; every result is compared against a bit-exact
// predictor with round to nearest even and flush to zero
// ----------------------------------------------------------------------------
module tb_binary64_add_sub_mul_div;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] FRAC_M  = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] HID     = 64'h0010_0000_0000_0000;
  localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NEG_INF = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] NEG_Z   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE     = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] MAXF    = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MINN    = 64'h0010_0000_0000_0000;
  localparam int          N_RAND  = 1030;
  localparam int          LATENCY = 73;

  typedef struct packed {
    logic [63:0] value;
    logic        ovf;
    logic        unf;
  } fp_out_t;

  // one directed row: known marks that exp holds a typed-in expectation
  typedef struct {
    b64_pkg::op_t op;
    logic [63:0]  a;
    logic [63:0]  b;
    logic         known;
    fp_out_t      exp;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   failed = 1'b0;
  fp_out_t expected_results[$];

  b64_req_if req ();
  b64_rsp_if rsp ();

  binary64_add_sub_mul_div dut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic fp_out_t plain(logic [63:0] v);
    return '{value: v, ovf: 1'b0, unf: 1'b0};
  endfunction

  function automatic logic [63:0] inf_of(logic s);
    return {s, b64_pkg::EXP_MAX, 52'd0};
  endfunction

  function automatic logic [63:0] zero_of(logic s);
    return {s, 63'd0};
  endfunction

  // m holds its leading one at bit 62; rounds on the 10 bits below the 53 kept
  function automatic fp_out_t round_pack(logic s, int e, logic [63:0] m);
    logic [63:0] keep;
    logic [9:0]  rem;
    keep = m >> 10;
    rem  = m[9:0];
    if (rem > b64_pkg::HALF || (rem == b64_pkg::HALF && keep[0])) keep++;
    if (keep == (HID << 1)) begin
      keep >>= 1;
      e++;
    end
    if (e >= 2047) return '{value: inf_of(s), ovf: 1'b1, unf: 1'b0};
    if (e <= 0) return '{value: zero_of(s), ovf: 1'b0, unf: 1'b1};
    return plain({s, e[10:0], keep[51:0]});
  endfunction

  function automatic fp_out_t sum_of(logic [63:0] a, logic [63:0] b);
    logic        sa, sb, ts;
    int          ea, eb, te, d, e;
    logic [63:0] ma, mb, m, tm;
    sa = a[63]; sb = b[63];
    ea = a[62:52]; eb = b[62:52];
    if ((ea == 2047 && a[51:0] != 0) || (eb == 2047 && b[51:0] != 0))
      return plain(b64_pkg::QNAN);
    if (ea == 2047 && eb == 2047) return plain(sa == sb ? inf_of(sa) : b64_pkg::QNAN);
    if (ea == 2047) return plain(inf_of(sa));
    if (eb == 2047) return plain(inf_of(sb));
    if (ea == 0 && eb == 0) return plain(zero_of(sa & sb));
    if (ea == 0) return plain(b);
    if (eb == 0) return plain(a);
    ma = ((a & FRAC_M) | HID) << 9;
    mb = ((b & FRAC_M) | HID) << 9;
    if (eb > ea || (eb == ea && mb > ma)) begin
      te = ea; ea = eb; eb = te;
      tm = ma; ma = mb; mb = tm;
      ts = sa; sa = sb; sb = ts;
    end
    d = ea - eb;
    if (d >= 63) mb = 64'd1;
    else begin
      tm = mb & ((64'd1 << d) - 1);
      mb >>= d;
      if (tm != 0) mb[0] = 1'b1;
    end
    m = (sa == sb) ? ma + mb : ma - mb;
    if (m == 0) return plain(64'd0);
    e = ea + 1;
    while (!m[62]) begin
      m <<= 1;
      e--;
    end
    return round_pack(sa, e, m);
  endfunction

  function automatic fp_out_t product_of(logic [63:0] a, logic [63:0] b);
    logic         s;
    int           ea, eb, e, k;
    logic [127:0] p;
    logic [63:0]  m;
    s = a[63] ^ b[63];
    ea = a[62:52]; eb = b[62:52];
    if ((ea == 2047 && a[51:0] != 0) || (eb == 2047 && b[51:0] != 0))
      return plain(b64_pkg::QNAN);
    if ((ea == 2047 && eb == 0) || (eb == 2047 && ea == 0)) return plain(b64_pkg::QNAN);
    if (ea == 2047 || eb == 2047) return plain(inf_of(s));
    if (ea == 0 || eb == 0) return plain(zero_of(s));
    p = {64'd0, (a & FRAC_M) | HID} * {64'd0, (b & FRAC_M) | HID};
    e = ea + eb - 1023;
    // product has its top at bit 105 or 104; align that to bit 62
    if (p[105]) begin
      k = 43; e++;
    end else k = 42;
    m = 64'(p >> k);
    if ((p & ((128'd1 << k) - 1)) != 0) m[0] = 1'b1;
    return round_pack(s, e, m);
  endfunction

  function automatic fp_out_t quotient_of(logic [63:0] a, logic [63:0] b);
    logic        s;
    int          ea, eb, e;
    logic [63:0] r, mb, q;
    s = a[63] ^ b[63];
    ea = a[62:52]; eb = b[62:52];
    if ((ea == 2047 && a[51:0] != 0) || (eb == 2047 && b[51:0] != 0))
      return plain(b64_pkg::QNAN);
    if ((ea == 2047 && eb == 2047) || (ea == 0 && eb == 0)) return plain(b64_pkg::QNAN);
    if (ea == 2047) return plain(inf_of(s));
    if (eb == 2047) return plain(zero_of(s));
    if (ea == 0) return plain(zero_of(s));
    if (eb == 0) return plain(inf_of(s));
    r = (a & FRAC_M) | HID;
    mb = (b & FRAC_M) | HID;
    q = 64'd0;
    e = ea - eb + 1023;
    if (r < mb) begin
      r <<= 1;
      e--;
    end
    for (int i = 62; i >= 0; i--) begin
      if (r >= mb) begin
        r -= mb;
        q[i] = 1'b1;
      end
      r <<= 1;
    end
    if (r != 0) q[0] = 1'b1;
    return round_pack(s, e, q);
  endfunction

  function automatic fp_out_t arith_result(b64_pkg::op_t op, logic [63:0] a,
                                           logic [63:0] b);
    case (op)
      b64_pkg::OP_ADD: return sum_of(a, b);
      b64_pkg::OP_SUB: return sum_of(a, b ^ NEG_Z);
      b64_pkg::OP_MUL: return product_of(a, b);
      default: return quotient_of(a, b);
    endcase
  endfunction

  // random operand: mostly normals near 1.0 or a given exponent, some specials
  function automatic logic [63:0] rand_operand(int near_exp);
    logic [63:0] v;
    int          k;
    v = {$urandom, $urandom};
    k = $urandom_range(0, 19);
    if (k < 10) v[62:52] = 11'(near_exp + $urandom_range(0, 8) - 4);
    else if (k == 10) v[62:52] = 11'd0;
    else if (k == 11) v[62:52] = 11'h7ff;
    else if (k == 12) v[51:0] = 52'd0;
    else if (k == 13) v[62:52] = 11'($urandom_range(1, 3));
    else if (k == 14) v[62:52] = 11'($urandom_range(2043, 2046));
    return v;
  endfunction

  // random gap: mostly none or short, now and then long
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 15);
    if (n < 9) n = 0;
    else if (n < 15) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // drive one request and hold it until accepted
  task automatic send_request(b64_pkg::op_t op, logic [63:0] a, logic [63:0] b);
    req.valid     <= 1'b1;
    req.opcode    <= op;
    req.operand_a <= a;
    req.operand_b <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_results.push_back(arith_result(op, a, b));
  endtask

  // one request plus, at random, a gap after it
  task automatic issue(b64_pkg::op_t op, logic [63:0] a, logic [63:0] b, bit gaps);
    send_request(op, a, b);
    if (gaps && $urandom_range(0, 2) == 0) begin
      idle_gap();
    end
  endtask

  // directed rows
  vec_t vecs[$];

  task automatic add_row(b64_pkg::op_t op, logic [63:0] a, logic [63:0] b,
                         bit known = 1'b0, fp_out_t e = '0);
    vecs.push_back('{op: op, a: a, b: b, known: known, exp: e});
  endtask

  initial begin
    req.valid     = 1'b0;
    req.opcode    = b64_pkg::OP_ADD;
    req.operand_a = '0;
    req.operand_b = '0;
  end

  // response side: random back-pressure, compare in order
  initial begin
    fp_out_t exp;
    bit      stall_free;
    rsp.ready = 1'b0;
    stall_free = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      // periods with ready held high, and periods with random stalls
      if ($urandom_range(0, 63) == 0) stall_free = !stall_free;
      if (stall_free) rsp.ready <= 1'b1;
      else begin
        int n;
        n = $urandom_range(0, 15);
        if (n == 15) begin
          rsp.ready <= 1'b0;
          repeat ($urandom_range(8, 40)) @(posedge clk);
          rsp.ready <= 1'b1;
        end else begin
          rsp.ready <= (n < 11);
        end
      end
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: value %h", rsp.result_value);
          failed = 1'b1;
        end else begin
          exp = expected_results.pop_front();
          if (rsp.result_value !== exp.value) begin
            $error("result_value: expected %h actual %h", exp.value, rsp.result_value);
            failed = 1'b1;
          end
          if (rsp.overflow_flag !== exp.ovf) begin
            $error("overflow_flag: expected %b actual %b", exp.ovf, rsp.overflow_flag);
            failed = 1'b1;
          end
          if (rsp.underflow_flag !== exp.unf) begin
            $error("underflow_flag: expected %b actual %b", exp.unf, rsp.underflow_flag);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    fp_out_t      got;
    int           near_exp;
    b64_pkg::op_t op;
    // extremes, each opcode, and the special cases
    add_row(b64_pkg::OP_ADD, ONE, ONE, 1'b1, plain(64'h4000_0000_0000_0000));
    add_row(b64_pkg::OP_SUB, ONE, ONE, 1'b1, plain(64'd0));         // exact cancellation
    add_row(b64_pkg::OP_MUL, ONE, ONE, 1'b1, plain(ONE));
    add_row(b64_pkg::OP_DIV, ONE, ONE, 1'b1, plain(ONE));
    add_row(b64_pkg::OP_ADD, 64'h7FF0_0000_0000_0001, ONE, 1'b1,
            plain(b64_pkg::QNAN));                                    // nan, low fraction
    add_row(b64_pkg::OP_MUL, ONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, plain(b64_pkg::QNAN));
    add_row(b64_pkg::OP_SUB, POS_INF, POS_INF, 1'b1, plain(b64_pkg::QNAN)); // inf minus inf
    add_row(b64_pkg::OP_ADD, POS_INF, POS_INF, 1'b1, plain(POS_INF));
    add_row(b64_pkg::OP_MUL, 64'd0, NEG_INF, 1'b1, plain(b64_pkg::QNAN));   // zero times inf
    add_row(b64_pkg::OP_DIV, NEG_Z, 64'd0, 1'b1, plain(b64_pkg::QNAN));     // zero over zero
    add_row(b64_pkg::OP_DIV, POS_INF, NEG_INF, 1'b1, plain(b64_pkg::QNAN)); // inf over inf
    add_row(b64_pkg::OP_DIV, ONE, NEG_INF, 1'b1, plain(NEG_Z));      // finite over inf
    add_row(b64_pkg::OP_DIV, NEG_INF, ONE, 1'b1, plain(NEG_INF));
    add_row(b64_pkg::OP_DIV, ONE ^ NEG_Z, 64'd0, 1'b1, plain(NEG_INF)); // division by zero
    add_row(b64_pkg::OP_ADD, NEG_Z, NEG_Z, 1'b1, plain(NEG_Z));      // both negative zero
    add_row(b64_pkg::OP_ADD, NEG_Z, 64'd0, 1'b1, plain(64'd0));
    add_row(b64_pkg::OP_ADD, 64'h000F_FFFF_FFFF_FFFF, MAXF, 1'b1, plain(MAXF)); // flush
    add_row(b64_pkg::OP_MUL, MAXF, MAXF, 1'b1, '{value: POS_INF, ovf: 1'b1, unf: 1'b0});
    add_row(b64_pkg::OP_MUL, MINN, MINN ^ NEG_Z, 1'b1,
            '{value: NEG_Z, ovf: 1'b0, unf: 1'b1});
    add_row(b64_pkg::OP_ADD, MAXF, MAXF, 1'b1, '{value: POS_INF, ovf: 1'b1, unf: 1'b0});
    add_row(b64_pkg::OP_SUB, 64'h0018_0000_0000_0000, MINN);         // result just below normal
    add_row(b64_pkg::OP_SUB, ONE, 64'h3FEF_FFFF_FFFF_FFFF);          // deep renormalize
    add_row(b64_pkg::OP_ADD, ONE, 64'h3CA0_0000_0000_0000);          // tie to even
    add_row(b64_pkg::OP_ADD, MAXF, 64'h0000_0000_0000_0001 | MINN);  // huge exponent gap
    add_row(b64_pkg::OP_DIV, MINN, MAXF);                            // quotient underflow

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (vecs[i]) begin
      if (vecs[i].known) begin
        got = arith_result(vecs[i].op, vecs[i].a, vecs[i].b);
        if (got !== vecs[i].exp) begin
          $error("directed row %0d: expected %h actual %h", i, vecs[i].exp, got);
          failed = 1'b1;
        end
      end
      issue(vecs[i].op, vecs[i].a, vecs[i].b, 1'b1);
    end

    // random part, with stretches of back-to-back requests
    for (int i = 0; i < N_RAND; i++) begin
      op = b64_pkg::op_t'($urandom_range(0, 3));
      near_exp = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2046) : 1023;
      // sender waits for the pipe to drain once, mid run
      if (i == N_RAND / 2) begin
        req.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
      end
      issue(op, rand_operand(near_exp), rand_operand(near_exp), (i / 128) % 2 == 0);
    end
    req.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (!failed) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
